// ----- design/acl_pkg.sv -----
`timescale 1ns / 1ps

package acl_pkg;

  // Default width of the internal offset and length counters.
  localparam int SIZE_BITS_DEF = 40;

  // Width of the reported total size.
  localparam int TOTAL_W = 40;

  // Characters checked in the header and in atom types.
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_E = 8'h45;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_D = 8'h44;
  localparam logic [7:0] CH_1 = 8'h31;

  // Smallest legal atom size (size field plus type field).
  localparam logic [31:0] MIN_ATOM_SIZE = 32'd8;

  // Header positions that are checked.
  localparam logic [3:0] POS_SIZE_LAST = 4'd3;
  localparam logic [3:0] POS_MAGIC_0   = 4'd4;
  localparam logic [3:0] POS_MAGIC_1   = 4'd5;
  localparam logic [3:0] POS_MAGIC_2   = 4'd6;
  localparam logic [3:0] POS_MAGIC_3   = 4'd7;
  localparam logic [3:0] POS_TAG_0     = 4'hA;
  localparam logic [3:0] POS_TAG_1     = 4'hB;

  // Byte positions inside one atom.
  localparam logic [2:0] REL_TYPE_0 = 3'd4;
  localparam logic [2:0] REL_TYPE_1 = 3'd5;
  localparam logic [2:0] REL_JUDGE  = 3'd6;
  localparam logic [2:0] REL_SIZE_0 = 3'd0;

  // Walk status codes as seen on the result channel.
  typedef enum logic [1:0] {
    ST_WALK   = 2'd0,
    ST_NOTFMT = 2'd1,
    ST_BAD    = 2'd2,
    ST_END    = 2'd3
  } acl_status_t;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
  } acl_item_t;

  // One result word.
  typedef struct packed {
    acl_status_t        status;
    logic [TOTAL_W-1:0] total_size;
  } acl_result_t;

endpackage

// ----- design/acl_in_reg.sv -----
`timescale 1ns / 1ps

module acl_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              drain,
  input  acl_pkg::acl_item_t item_in,
  output logic              vld_r,
  output acl_pkg::acl_item_t item_r
);
  import acl_pkg::*;

  logic vld_nxt;

  // The register holds a word until the walk stage consumes it.
  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (drain) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

endmodule

// ----- design/acl_walk.sv -----
`timescale 1ns / 1ps

module acl_walk #(
  parameter int SIZE_BITS = acl_pkg::SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  acl_pkg::acl_item_t  item,
  output acl_pkg::acl_result_t res_r
);
  import acl_pkg::*;

  localparam logic [SIZE_BITS-1:0] OFF_MAX = {SIZE_BITS{1'b1}};

  // Walk state.
  logic [SIZE_BITS-1:0] byte_offset_r, byte_offset_nxt;
  logic [SIZE_BITS-1:0] next_atom_r, next_atom_nxt;
  logic [31:0]          size_acc_r, size_acc_nxt;
  logic [15:0]          type_prefix_r, type_prefix_nxt;
  acl_status_t          status_r, status_nxt;
  acl_result_t          res_nxt;

  // State as seen by this word, after a possible restart.
  logic [SIZE_BITS-1:0] pos;
  logic [SIZE_BITS-1:0] next_b;
  logic [31:0]          acc_b;
  logic [15:0]          tp_b;
  acl_status_t          st_b;

  logic [7:0]           b;
  logic [31:0]          acc_shift;
  logic                 hdr_ok;
  logic [SIZE_BITS:0]   rel_diff;
  logic [SIZE_BITS-1:0] rel;
  logic                 in_atom;
  logic [SIZE_BITS:0]   sum;
  logic [SIZE_BITS+TOTAL_W-1:0] next_ext;

  assign b         = item.byte_value;
  assign acc_shift = {acc_b[23:0], b};

  // Restart on the first byte of a new file.
  always_comb begin
    if (item.first_byte) begin
      pos    = '0;
      next_b = '0;
      acc_b  = '0;
      tp_b   = '0;
      st_b   = ST_WALK;
    end else begin
      pos    = byte_offset_r;
      next_b = next_atom_r;
      acc_b  = size_acc_r;
      tp_b   = type_prefix_r;
      st_b   = status_r;
    end
  end

  // Header check on the fixed positions near the start of the file.
  always_comb begin
    hdr_ok = 1'b1;
    if (pos[SIZE_BITS-1:4] == '0) begin
      unique case (pos[3:0])
        POS_SIZE_LAST: hdr_ok = (acc_shift >= MIN_ATOM_SIZE);
        POS_MAGIC_0:   hdr_ok = (b == CH_R);
        POS_MAGIC_1:   hdr_ok = (b == CH_E);
        POS_MAGIC_2:   hdr_ok = (b == CH_D);
        POS_MAGIC_3:   hdr_ok = (b == CH_1);
        POS_TAG_0:     hdr_ok = (b == CH_R);
        POS_TAG_1:     hdr_ok = (b == CH_1);
        default:       hdr_ok = 1'b1;
      endcase
    end
  end

  // Position within the current atom, and the candidate end of the atom.
  assign rel_diff = {1'b0, pos} - {1'b0, next_b};
  assign rel      = rel_diff[SIZE_BITS-1:0];
  assign in_atom  = !rel_diff[SIZE_BITS] && (rel[SIZE_BITS-1:3] == '0);
  assign sum      = {1'b0, next_b} + {{(SIZE_BITS-31){1'b0}}, acc_b};

  // Next state for one byte.
  always_comb begin
    next_atom_nxt   = next_b;
    size_acc_nxt    = acc_b;
    type_prefix_nxt = tp_b;
    status_nxt      = st_b;
    if (st_b == ST_WALK) begin
      priority if (pos == OFF_MAX) begin
        status_nxt = ST_BAD;
      end else if (!hdr_ok) begin
        status_nxt = ST_NOTFMT;
      end else if (in_atom) begin
        priority case (rel[2:0])
          REL_SIZE_0: size_acc_nxt    = {24'd0, b};
          REL_TYPE_0: type_prefix_nxt = {8'd0, b};
          REL_TYPE_1: type_prefix_nxt = {tp_b[7:0], b};
          REL_JUDGE: begin
            // Judge the atom: bad size, bad type or an overflowing end stops, else skip by its size.
            if (acc_b < MIN_ATOM_SIZE || tp_b[15:8] != CH_R) begin
              status_nxt = ST_BAD;
            end else if (sum[SIZE_BITS]) begin
              status_nxt = ST_BAD;
            end else begin
              next_atom_nxt = sum[SIZE_BITS-1:0];
              status_nxt    = (tp_b[7:0] == CH_E && b == CH_O) ? ST_END : ST_WALK;
            end
          end
          3'd7: begin
          end
          default: size_acc_nxt = acc_shift;
        endcase
      end
    end
    byte_offset_nxt = (pos == OFF_MAX) ? pos : pos + 1'b1;
  end

  // Result word: the total is the low bits of the next atom start, or zero on ST_NOTFMT.
  assign next_ext = {{TOTAL_W{1'b0}}, next_atom_nxt};
  always_comb begin
    res_nxt.status     = status_nxt;
    res_nxt.total_size = (status_nxt == ST_NOTFMT) ? '0 : next_ext[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_offset_r <= '0;
      next_atom_r   <= '0;
      size_acc_r    <= '0;
      type_prefix_r <= '0;
      status_r      <= ST_WALK;
    end else if (adv) begin
      byte_offset_r <= byte_offset_nxt;
      next_atom_r   <= next_atom_nxt;
      size_acc_r    <= size_acc_nxt;
      type_prefix_r <= type_prefix_nxt;
      status_r      <= status_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ----- design/atom_chain_length_tracker.sv -----
`timescale 1ns / 1ps

// Channel  Direction  Bits           Contents
// in_      slave      tdata[7:0]     byte_value
//                     tuser[0]       first_byte
// out_     master     tdata[39:0]    total_size
//                     tuser[1:0]     status
//
// A word passes the input register and then the result register. The
// throughput of one word per cycle, barring a result-side stall, is set
// by the single walk stage, which updates the atom state and the result
// register in one step. Reset clears the valid flags and restarts the walk
// at offset zero. A stall on the result side holds the result and then the
// input register; the input side is refused only while both are full.

module atom_chain_length_tracker #(
  parameter int SIZE_BITS = acl_pkg::SIZE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_value
  input  logic [0:0]  in_tuser,   // [0] first_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [39:0] total_size
  output logic [1:0]  out_tuser   // [1:0] status
);
  import acl_pkg::*;

  acl_item_t   item_in;
  acl_item_t   item_r;
  acl_result_t res_r;
  logic        in_vld_r;
  logic        out_vld_r, out_vld_nxt;
  logic        adv;
  logic        load;

  // The walk stage moves whenever it holds a word and the result slot frees.
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;
  assign load      = in_tvalid && in_tready;

  assign item_in.byte_value = in_tdata;
  assign item_in.first_byte = in_tuser[0];

  acl_in_reg u_in_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .drain   (adv),
    .item_in (item_in),
    .vld_r   (in_vld_r),
    .item_r  (item_r)
  );

  acl_walk #(
    .SIZE_BITS (SIZE_BITS)
  ) u_walk (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item_r),
    .res_r (res_r)
  );

  // Result valid flag.
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = res_r.total_size;
  assign out_tuser  = res_r.status;

endmodule
